// ----- sv/spfs_pkg.sv -----
// ----------------------------------------------------------------------------
// spfs_pkg: shared definitions for the smallest prime factor sieve
// sizes, limits, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package spfs_pkg;

  localparam int TABLE_SIZE  = 65536;
  localparam int PRIME_SLOTS = 8192;
  localparam int TAW         = $clog2(TABLE_SIZE);
  localparam int PAW         = $clog2(PRIME_SLOTS);

  // field widths of the request and response
  localparam int VAL_W = 16;
  localparam int CNT_W = 13;

  // largest limit a build can cover
  localparam logic [VAL_W-1:0] LIMIT_MAX = VAL_W'(TABLE_SIZE - 1);
  localparam logic [VAL_W-1:0] LIMIT_MIN = VAL_W'(2);

  // prime list capacity, also bounded by the count field
  localparam int PRIME_CAP_I = (PRIME_SLOTS < 8191) ? PRIME_SLOTS : 8191;
  localparam logic [CNT_W-1:0] PRIME_CAP = CNT_W'(PRIME_CAP_I);

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Q_RESP,
    ST_B_READ,
    ST_B_EVAL,
    ST_P_READ,
    ST_P_MUL,
    ST_P_MARK,
    ST_B_DONE
  } spfs_state_t;

  typedef struct packed {
    logic clr_wr;   // clear one mark entry, advance sweep
    logic q_rd;     // query accepted, start table read
    logic q_load;   // load query response
    logic b_init;   // build accepted, latch limit
    logic b_rd;     // read mark and factor at i
    logic b_eval;   // classify i, record prime
    logic p_rd;     // read prime list at j
    logic p_mul;    // form i*p
    logic p_mark;   // mark i*p, advance j
    logic i_inc;    // advance i
    logic b_done;   // load build response
  } spfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic list_end;
    logic m_over;
    logic p_is_spf;
    logic i_last;
  } spfs_sts_t;

endpackage

// ----- sv/spfs_if.sv -----
// ----------------------------------------------------------------------------
// spfs channel interfaces
// request, response and configuration write channels
// ----------------------------------------------------------------------------
interface spfs_in_if
  import spfs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [VAL_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface spfs_out_if
  import spfs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] smallest_factor;
  logic             is_prime;
  logic             status;
  logic [CNT_W-1:0] prime_count;

  modport source (output valid, smallest_factor, is_prime, status, prime_count,
                  input ready);
  modport sink   (input valid, smallest_factor, is_prime, status, prime_count,
                  output ready);
endinterface

interface spfs_cfg_if
  import spfs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/spfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// spfs_ctrl: sequencer of the sieve
// steps the clearing sweep, queries and the linear sieve build
// ----------------------------------------------------------------------------
module spfs_ctrl
  import spfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  spfs_sts_t sts,
  output spfs_cmd_t cmd
);

  spfs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc;
  logic        leave_i;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // inner loop over primes is over for this i
  always_comb begin
    leave_i = 1'b0;
    case (state_r)
      ST_P_READ: leave_i = sts.list_end;
      ST_P_MARK: leave_i = sts.m_over || sts.p_is_spf;
      default:   leave_i = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_func == FUNC_QUERY) ? ST_Q_RESP : ST_B_READ;
      end
      ST_Q_RESP: state_nxt = ST_IDLE;
      ST_B_READ: state_nxt = ST_B_EVAL;
      ST_B_EVAL: state_nxt = ST_P_READ;
      ST_P_READ: begin
        if (leave_i) state_nxt = sts.i_last ? ST_B_DONE : ST_B_READ;
        else         state_nxt = ST_P_MUL;
      end
      ST_P_MUL:  state_nxt = ST_P_MARK;
      ST_P_MARK: begin
        if (leave_i) state_nxt = sts.i_last ? ST_B_DONE : ST_B_READ;
        else         state_nxt = ST_P_READ;
      end
      ST_B_DONE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR:  cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd.q_rd   = in_acc && (in_func == FUNC_QUERY);
        cmd.b_init = in_acc && (in_func == FUNC_BUILD);
      end
      ST_Q_RESP: cmd.q_load = 1'b1;
      ST_B_READ: cmd.b_rd   = 1'b1;
      ST_B_EVAL: cmd.b_eval = 1'b1;
      ST_P_READ: begin
        cmd.p_rd  = !leave_i;
        cmd.i_inc = leave_i && !sts.i_last;
      end
      ST_P_MUL:  cmd.p_mul  = 1'b1;
      ST_P_MARK: begin
        cmd.p_mark = 1'b1;
        cmd.i_inc  = leave_i && !sts.i_last;
      end
      ST_B_DONE: cmd.b_done = 1'b1;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.q_load || cmd.b_done) out_valid_nxt = 1'b1;
    else if (out_ready)           out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/spfs_dp.sv -----
// ----------------------------------------------------------------------------
// spfs_dp: sieve datapath
// factor table, composite marks, prime list, counters and response register
// ----------------------------------------------------------------------------
module spfs_dp
  import spfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  spfs_cmd_t        cmd,
  output spfs_sts_t        sts,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_data,
  output logic [VAL_W-1:0] smallest_factor,
  output logic             is_prime,
  output logic             status,
  output logic [CNT_W-1:0] prime_count
);

  // storage
  logic [VAL_W-1:0] ftab_mem  [TABLE_SIZE];
  logic             mark_mem  [TABLE_SIZE];
  logic [VAL_W-1:0] plist_mem [PRIME_SLOTS];

  logic [VAL_W-1:0] ftab_rd_r, plist_rd_r;
  logic             mark_rd_r;

  logic [VAL_W-1:0]   sieve_limit_r, lim_r, lim_nxt, built_r;
  logic [VAL_W-1:0]   i_r, spf_r, p_r, q_val_r;
  logic [TAW-1:0]     clr_addr_r;
  logic [CNT_W-1:0]   total_r, j_r;
  logic [2*VAL_W-1:0] m_r;
  logic               spf_hit_r;

  logic [VAL_W-1:0] factor_r;
  logic             prime_r, status_r;
  logic [CNT_W-1:0] count_r;

  logic             mark_we, mark_wd;
  logic [TAW-1:0]   mark_wa;
  logic             ftab_we, ftab_re;
  logic [TAW-1:0]   ftab_wa, ftab_ra;
  logic [VAL_W-1:0] ftab_wd;
  logic             plist_we;
  logic             new_prime, mark_ok;

  assign new_prime = cmd.b_eval && !mark_rd_r;
  assign mark_ok   = cmd.p_mark && !sts.m_over;

  always_comb begin
    if (sieve_limit_r < LIMIT_MIN)      lim_nxt = LIMIT_MIN;
    else if (sieve_limit_r > LIMIT_MAX) lim_nxt = LIMIT_MAX;
    else                                lim_nxt = sieve_limit_r;
  end

  assign sts.clr_last = (clr_addr_r == {TAW{1'b1}});
  assign sts.list_end = (j_r >= total_r);
  assign sts.m_over   = (m_r > {{VAL_W{1'b0}}, lim_r});
  assign sts.p_is_spf = spf_hit_r;
  assign sts.i_last   = (i_r == lim_r);

  // mark write port: sweep clear, clear-after-read at i, mark of i*p
  always_comb begin
    mark_we = 1'b0;
    mark_wa = '0;
    mark_wd = 1'b0;
    if (cmd.clr_wr) begin
      mark_we = 1'b1;
      mark_wa = clr_addr_r;
    end else if (cmd.b_eval) begin
      mark_we = 1'b1;
      mark_wa = TAW'(i_r);
    end else if (mark_ok) begin
      mark_we = 1'b1;
      mark_wa = TAW'(m_r[VAL_W-1:0]);
      mark_wd = 1'b1;
    end
  end

  always_comb begin
    ftab_we = 1'b0;
    ftab_wa = '0;
    ftab_wd = '0;
    if (new_prime) begin
      ftab_we = 1'b1;
      ftab_wa = TAW'(i_r);
      ftab_wd = i_r;
    end else if (mark_ok) begin
      ftab_we = 1'b1;
      ftab_wa = TAW'(m_r[VAL_W-1:0]);
      ftab_wd = p_r;
    end
  end

  assign ftab_re  = cmd.q_rd || cmd.b_rd;
  assign ftab_ra  = cmd.q_rd ? TAW'(in_value) : TAW'(i_r);
  assign plist_we = new_prime && (total_r < PRIME_CAP);

  always_ff @(posedge clk) begin
    if (ftab_we) ftab_mem[ftab_wa] <= ftab_wd;
    if (ftab_re) ftab_rd_r <= ftab_mem[ftab_ra];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd.b_rd) mark_rd_r <= mark_mem[TAW'(i_r)];
  end

  always_ff @(posedge clk) begin
    if (plist_we) plist_mem[PAW'(total_r)] <= i_r;
    if (cmd.p_rd) plist_rd_r <= plist_mem[PAW'(j_r)];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sieve_limit_r <= {VAL_W{1'b1}};
      built_r       <= '0;
      total_r       <= '0;
      clr_addr_r    <= '0;
    end else begin
      if (cfg_we)     sieve_limit_r <= cfg_data;
      if (cmd.clr_wr) clr_addr_r    <= clr_addr_r + TAW'(1);
      if (cmd.b_init) total_r       <= '0;
      else if (plist_we) total_r    <= total_r + CNT_W'(1);
      if (cmd.b_done) built_r       <= lim_r;
    end
  end

  // build working registers
  always_ff @(posedge clk) begin
    if (cmd.b_init) begin
      lim_r <= lim_nxt;
      i_r   <= LIMIT_MIN;
    end else if (cmd.i_inc) begin
      i_r <= i_r + VAL_W'(1);
    end
    if (cmd.b_eval) begin
      spf_r <= mark_rd_r ? ftab_rd_r : i_r;
      j_r   <= '0;
    end else if (cmd.p_mark) begin
      j_r <= j_r + CNT_W'(1);
    end
    if (cmd.p_mul) begin
      m_r       <= (2*VAL_W)'(i_r) * (2*VAL_W)'(plist_rd_r);
      p_r       <= plist_rd_r;
      spf_hit_r <= (plist_rd_r == spf_r);
    end
    if (cmd.q_rd) q_val_r <= in_value;
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      count_r <= total_r;
      if (built_r == '0 || q_val_r > built_r) begin
        factor_r <= '0;
        prime_r  <= 1'b0;
        status_r <= STATUS_RANGE;
      end else if (q_val_r >= LIMIT_MIN) begin
        factor_r <= ftab_rd_r;
        prime_r  <= (ftab_rd_r == q_val_r);
        status_r <= STATUS_OK;
      end else begin
        factor_r <= '0;
        prime_r  <= 1'b0;
        status_r <= STATUS_OK;
      end
    end else if (cmd.b_done) begin
      count_r  <= total_r;
      factor_r <= '0;
      prime_r  <= 1'b0;
      status_r <= STATUS_OK;
    end
  end

  assign smallest_factor = factor_r;
  assign is_prime        = prime_r;
  assign status          = status_r;
  assign prime_count     = count_r;

endmodule

// ----- sv/smallest_prime_factor_sieve_top.sv -----
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_top: linear sieve smallest prime factor table
// builds the table on request up to the configured limit, then answers queries
// ----------------------------------------------------------------------------
// After reset the block clears its composite mark memory (one entry a cycle)
// and takes no request until that is done; configuration writes are taken at
// any time. A query (func 1) goes from accept through the registered factor
// table read to the state that forms the response. A rebuild (func 0) walks
// every value i from 2 to the limit through one shared multiplier and
// single-port memories: per value, a read and an evaluate state classify its
// mark, then each prime tried passes through prime list read, multiply and
// mark write; the loop over primes ends at the smallest factor of i, at the
// first multiple past the limit, or when the prime list runs out; a final
// state loads the response. One request is in flight at a time, and a new
// request is taken as the previous response is being taken.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_top
  import spfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spfs_in_if.sink    in_req,
  spfs_out_if.source out_rsp,
  spfs_cfg_if.sink   cfg_wr
);

  spfs_cmd_t cmd;
  spfs_sts_t sts;

  // limit register is always writable
  assign cfg_wr.ready = 1'b1;

  // sequencer: clearing sweep, query response, sieve loop over i and primes
  spfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_func   (in_req.func),
    .in_ready  (in_req.ready),
    .out_ready (out_rsp.ready),
    .out_valid (out_rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories, counters, multiplier and the response register
  spfs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value        (in_req.value),
    .cfg_we          (cfg_wr.valid && cfg_wr.ready),
    .cfg_data        (cfg_wr.data),
    .smallest_factor (out_rsp.smallest_factor),
    .is_prime        (out_rsp.is_prime),
    .status          (out_rsp.status),
    .prime_count     (out_rsp.prime_count)
  );

  // a query request gets its response loaded in the next cycle
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.func == FUNC_QUERY) |=> cmd.q_load)
    else $error("query response not loaded after table read");

  // a response never overwrites one that is still waiting
  a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.q_load || cmd.b_done) |-> (!out_rsp.valid || out_rsp.ready))
    else $error("response register overwritten while pending");

  // no request is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_req.ready)
    else $error("request taken during mark clearing");

  // a build response only follows the last value of the sieve
  a_build_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.b_done |-> sts.i_last)
    else $error("build finished before reaching the limit");

endmodule

// ----- verif/smallest_prime_factor_sieve_top_tb.sv -----
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_top_tb: self-checking bench for the sieve
// A directed table covers the table sizes at both ends, queries before any
// build, zero, one, the largest values and out-of-range reads. Random phases
// follow, each with a new limit, a build and mostly in-range queries. Every
// response is checked field by field, against its typed-in answer or else a linear sieve kept in the bench.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_top_tb
  import spfs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // run length and pacing
  localparam int          RAND_PHASES     = 12;
  localparam int          PHASE_QUERIES   = 120;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          DRAIN_CYCLES    = 16;
  // clearing pass, one full build and a dozen mid-size builds, several times over
  localparam int unsigned CYCLE_LIMIT     = 10_000_000;
  localparam int          DIRECTED_ROWS   = 26;

  // one response as the block reports it
  typedef struct packed {
    logic [VAL_W-1:0] factor;
    logic             prime;
    logic             status;
    logic [CNT_W-1:0] count;
  } spf_answer_t;

  // rows of the directed table: a limit write, a rebuild or a query
  typedef enum logic [1:0] {
    ROW_QUERY,
    ROW_BUILD,
    ROW_SET_LIMIT
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [VAL_W-1:0] arg;      // query value, ignored rebuild value or limit
    bit               checked;  // answer typed in below, else from the sieve
    spf_answer_t      answer;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic hold_go;

  spfs_in_if  in_req ();
  spfs_out_if out_rsp ();
  spfs_cfg_if cfg_wr ();

  smallest_prime_factor_sieve_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  // bench copy of the sieve state
  logic [VAL_W-1:0] spf_table [TABLE_SIZE];
  bit               composite_seen [TABLE_SIZE];
  logic [VAL_W-1:0] prime_store [PRIME_SLOTS];
  int unsigned      primes_found  = 0;
  int unsigned      table_top     = 0;      // zero until the first build
  int unsigned      limit_setting = 65535;  // register value after reset

  // answers still owed by the block, oldest first
  spf_answer_t pending_answers [$];

  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int          send_idle_pct = 27;
  int          recv_idle_pct = 69;
  int unsigned sink_hold_left = 0;

  // run statistics for the closing summary
  int unsigned build_total   = 0;
  int unsigned query_total   = 0;
  int unsigned range_total   = 0;
  int unsigned prime_hits    = 0;
  int unsigned limit_writes  = 0;
  int unsigned widest_build  = 0;

  // directed requests; answers typed in where they follow at a glance
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // nothing built yet: every query is out of range
    '{ROW_QUERY,     16'd0,     1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd0}},
    '{ROW_QUERY,     16'd65535, 1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd0}},
    '{ROW_QUERY,     16'd2,     1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd0}},
    // limit of zero is raised to two: only the prime 2
    '{ROW_SET_LIMIT, 16'd0,     1'b0, '0},
    '{ROW_BUILD,     16'hFFFF,  1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd1}},
    '{ROW_QUERY,     16'd2,     1'b1, '{16'd2,  1'b1, STATUS_OK,    13'd1}},
    '{ROW_QUERY,     16'd3,     1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd1}},
    '{ROW_QUERY,     16'd1,     1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd1}},
    // limit of one is raised as well
    '{ROW_SET_LIMIT, 16'd1,     1'b0, '0},
    '{ROW_BUILD,     16'h0000,  1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd1}},
    '{ROW_QUERY,     16'd0,     1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd1}},
    // the full table
    '{ROW_SET_LIMIT, 16'd65535, 1'b0, '0},
    '{ROW_BUILD,     16'h5555,  1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd6542}},
    '{ROW_QUERY,     16'd65535, 1'b0, '0},
    '{ROW_QUERY,     16'd65521, 1'b0, '0},
    '{ROW_QUERY,     16'd65534, 1'b0, '0},
    '{ROW_QUERY,     16'd63001, 1'b0, '0},
    '{ROW_QUERY,     16'd32768, 1'b0, '0},
    '{ROW_QUERY,     16'd1,     1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd6542}},
    // a new limit only takes hold at the next build
    '{ROW_SET_LIMIT, 16'd100,   1'b0, '0},
    '{ROW_QUERY,     16'd100,   1'b0, '0},
    '{ROW_BUILD,     16'hAAAA,  1'b1, '{16'd0,  1'b0, STATUS_OK,    13'd25}},
    '{ROW_QUERY,     16'd101,   1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd25}},
    '{ROW_QUERY,     16'd97,    1'b1, '{16'd97, 1'b1, STATUS_OK,    13'd25}},
    '{ROW_QUERY,     16'd65535, 1'b1, '{16'd0,  1'b0, STATUS_RANGE, 13'd25}},
    '{ROW_QUERY,     16'd4,     1'b0, '0}
  };

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_answers.size());
      $display("smallest_prime_factor_sieve_top verification failed");
      $finish;
    end
  end

  // linear sieve over 2 .. limit, every composite marked once by its
  // smallest prime; the prime list stops growing at its capacity
  function automatic void sieve_rebuild();
    int unsigned top;
    int unsigned i;
    int unsigned j;
    int unsigned p;
    int unsigned m;
    top = limit_setting;
    if (top < LIMIT_MIN) top = LIMIT_MIN;
    if (top > LIMIT_MAX) top = LIMIT_MAX;
    for (i = 0; i < TABLE_SIZE; i++) composite_seen[i] = 1'b0;
    primes_found = 0;
    for (i = 2; i <= top; i++) begin
      if (!composite_seen[i]) begin
        spf_table[i] = VAL_W'(i);
        if (primes_found < PRIME_CAP_I) begin
          prime_store[primes_found] = VAL_W'(i);
          primes_found++;
        end
      end
      for (j = 0; j < primes_found; j++) begin
        p = prime_store[j];
        m = i * p;
        if (m > top) break;
        composite_seen[m] = 1'b1;
        spf_table[m]      = VAL_W'(p);
        if (i % p == 0) break;
      end
    end
    table_top = top;
  endfunction

  // answer for one accepted request; a rebuild updates the sieve first
  function automatic spf_answer_t predict_answer(input logic req_func,
                                                 input logic [VAL_W-1:0] req_value);
    spf_answer_t ans;
    ans        = '0;
    ans.status = STATUS_OK;
    if (req_func == FUNC_BUILD) begin
      sieve_rebuild();
    end else if (table_top == 0 || req_value > table_top) begin
      ans.status = STATUS_RANGE;
    end else if (req_value >= 2) begin
      ans.factor = spf_table[req_value];
      ans.prime  = (ans.factor == req_value);
    end
    ans.count = CNT_W'(primes_found);
    return ans;
  endfunction

  // query values weighted toward the built range, with edges and noise
  function automatic logic [VAL_W-1:0] pick_query_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return VAL_W'($urandom_range(3));
    if (r < 18) begin
      if (table_top < LIMIT_MAX) return VAL_W'($urandom_range(LIMIT_MAX, table_top + 1));
      return VAL_W'($urandom_range(LIMIT_MAX));
    end
    if (r < 25) return VAL_W'($urandom);
    if (r < 30) return VAL_W'(table_top + 1 - $urandom_range(2));
    return VAL_W'($urandom_range(table_top));
  endfunction

  // offer one request, idling at random first; valid stays high after
  // acceptance so back-to-back requests are offered without dropping valid between them
  task automatic push_request(input logic req_func, input logic [VAL_W-1:0] req_value,
                              input bit fixed, input spf_answer_t fixed_answer);
    spf_answer_t ans;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func  <= req_func;
    in_req.value <= req_value;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    // accepted at this edge
    ans = predict_answer(req_func, req_value);
    if (fixed) ans = fixed_answer;
    pending_answers.insert(pending_answers.size(), ans);
    if (req_func == FUNC_BUILD) begin
      build_total++;
      if (table_top > widest_build) widest_build = table_top;
    end else begin
      query_total++;
      if (ans.status == STATUS_RANGE) range_total++;
      if (ans.prime) prime_hits++;
    end
  endtask

  // limit writes only once every response is back and the block is idle
  task automatic write_limit(input logic [VAL_W-1:0] lim);
    in_req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= lim;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid  <= 1'b0;
    limit_setting = lim;
    limit_writes++;
  endtask

  task automatic flag_field(input string field_name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field_name, want, got);
    end
  endtask

  // response side: check each accepted response against the oldest answer
  // owed, then pick ready for the next edge
  initial begin
    spf_answer_t want;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_rsp.valid && out_rsp.ready) begin
        if (pending_answers.size() == 0) begin
          fail_count++;
          $display("%0t: unrequested response, expected none, actual factor %0d status %0d",
                   $time, out_rsp.smallest_factor, out_rsp.status);
        end else begin
          want = pending_answers.pop_front();
          flag_field("smallest_factor", want.factor, out_rsp.smallest_factor);
          flag_field("is_prime",        want.prime,  out_rsp.is_prime);
          flag_field("status",          want.status, out_rsp.status);
          flag_field("prime_count",     want.count,  out_rsp.prime_count);
        end
      end
      // long hold-off so the block backs up and stalls its request side
      if (hold_go) sink_hold_left = HOLD_CYCLES;
      if (sink_hold_left != 0) begin
        sink_hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // request side: reset, directed table, random phases, drain
  initial begin
    int          phase;
    int          k;
    int unsigned sel;
    int unsigned lim;
    rst_n        <= 1'b0;
    hold_go      <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.func  <= FUNC_QUERY;
    in_req.value <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the block sits in its clearing pass first,
    // the request handshake simply waits it out
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_SET_LIMIT: write_limit(directed_rows[r].arg);
        ROW_BUILD:     push_request(FUNC_BUILD, directed_rows[r].arg,
                                    directed_rows[r].checked, directed_rows[r].answer);
        default:       push_request(FUNC_QUERY, directed_rows[r].arg,
                                    directed_rows[r].checked, directed_rows[r].answer);
      endcase
    end

    // random phases: a fresh limit, a build, then mostly in-range queries
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      // idling: sender light and receiver heavy, then swapped, then none
      case (phase / (RAND_PHASES / 3))
        0: begin
          send_idle_pct =  27;
          recv_idle_pct <= 69;
        end
        1: begin
          send_idle_pct =  69;
          recv_idle_pct <= 27;
        end
        default: begin
          send_idle_pct =  0;
          recv_idle_pct <= 0;
        end
      endcase

      // mostly small limits to keep builds short, a few below four
      // and a few in the thousands
      sel = $urandom_range(11);
      if (sel == 0)      lim = $urandom_range(3);
      else if (sel == 1) lim = $urandom_range(8000, 3000);
      else               lim = $urandom_range(1500, 4);
      write_limit(VAL_W'(lim));

      if (phase == 1) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end

      // sometimes query the previous table before rebuilding
      if ($urandom_range(1)) begin
        repeat (3) push_request(FUNC_QUERY, pick_query_value(), 1'b0, '0);
      end
      push_request(FUNC_BUILD, VAL_W'($urandom), 1'b0, '0);

      for (k = 0; k < PHASE_QUERIES; k++) begin
        if ($urandom_range(99) == 0)
          push_request(FUNC_BUILD, VAL_W'($urandom), 1'b0, '0);
        else
          push_request(FUNC_QUERY, pick_query_value(), 1'b0, '0);
      end
    end

    in_req.valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      fail_count++;
      $display("%0d responses never arrived", pending_answers.size());
    end

    $display("ran %0d builds (widest limit %0d) and %0d queries over %0d limit writes",
             build_total, widest_build, query_total, limit_writes);
    $display("queries: %0d out of range, %0d primes; %0d cycles, %0d mismatches",
             range_total, prime_hits, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("smallest_prime_factor_sieve_top verification clean");
    end else begin
      $display("smallest_prime_factor_sieve_top verification failed");
    end
    $finish;
  end

endmodule
